### design/ghash_accumulator_defines.svh
// Assertion macros for the GHASH accumulator checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GHASH_ACCUMULATOR_DEFINES_SVH
`define GHASH_ACCUMULATOR_DEFINES_SVH

// Property checked out of reset
`define GHASH_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next, checked out of reset
`define GHASH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Property checked at every edge, reset included
`define GHASH_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ghash_pkg.sv
// Package for the GHASH accumulator: item structs, function codes, register indexes.
// Depends on nothing; used by ghash_accumulator and its checker.
package ghash_pkg;

	// Function codes of an input item
	localparam logic [1:0] FUNC_AAD    = 2'd0;
	localparam logic [1:0] FUNC_CIPHER = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	// Configuration register indexes
	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	// Bytes in one block
	localparam int BLOCK_BYTES = 16;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  byte_count;
	} ghash_in_t;

	typedef struct packed {
		logic [63:0] tag_high;
		logic [63:0] tag_low;
	} ghash_out_t;

endpackage

### design/ghash_accumulator.sv
// GHASH accumulator top level: input stage, GF(2^128) multiply and tag register.
// Depends on ghash_pkg for item structs, function codes and register indexes.
// A data item waits in the input stage after it is accepted, then folds into the
// accumulator; a finish item loads the tag register behind out_valid once it is free.
// Throughput: one item per cycle, set by the combinational GF(2^128) multiplier on
// the accumulator loop. in_ready drops only while a tag waits and a finish is staged.
// Reset: arst_n clears the key, accumulator, bit counters and all valid flags.
module ghash_accumulator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [63:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ghash_pkg::ghash_in_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ghash_pkg::ghash_out_t out_data
);

	// Carry-less multiply in GCM bit order, then reduce by x^128 + x^7 + x^2 + x + 1
	function automatic logic [127:0] gf_mul(input logic [127:0] x, input logic [127:0] h);
		logic [127:0] xr;
		logic [127:0] hr;
		logic [254:0] prod;
		logic [133:0] fold;
		logic [5:0]   over;
		logic [127:0] red;
		logic [127:0] res;
		for (int i = 0; i < 128; i++) begin
			xr[i] = x[127-i];
			hr[i] = h[127-i];
		end
		prod = '0;
		for (int i = 0; i < 128; i++) begin
			if (xr[i]) begin
				prod = prod ^ ({127'b0, hr} << i);
			end
		end
		// First fold of the upper half, then the few bits it pushes past degree 127
		fold = {7'b0, prod[254:128]} ^ ({7'b0, prod[254:128]} << 1)
			^ ({7'b0, prod[254:128]} << 2) ^ ({7'b0, prod[254:128]} << 7);
		over = fold[133:128];
		red = prod[127:0] ^ fold[127:0] ^ {122'b0, over} ^ ({122'b0, over} << 1)
			^ ({122'b0, over} << 2) ^ ({122'b0, over} << 7);
		for (int i = 0; i < 128; i++) begin
			res[i] = red[127-i];
		end
		return res;
	endfunction

	logic [63:0]  key_high_q;
	logic [63:0]  key_low_q;
	logic [127:0] acc_q;
	logic [63:0]  data_bits_q;
	logic [63:0]  cipher_bits_q;

	logic         valid_s1;
	logic         fin_s1;
	logic         aad_s1;
	logic [127:0] blk_s1;
	logic [7:0]   nbits_s1;

	logic         out_valid_q;
	ghash_pkg::ghash_out_t out_q;

	logic         in_fire;
	logic         in_keep;
	logic         in_data_item;
	logic [4:0]   nbytes;
	logic [7:0]   nbits;
	logic [127:0] keep_mask;
	logic         s1_go;
	logic [127:0] mul_in;
	logic [127:0] mul_out;

	// Write the hash key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ghash_pkg::CFG_KEY_HIGH) begin
				key_high_q <= cfg_wdata;
			end else begin
				key_low_q <= cfg_wdata;
			end
		end
	end

	// Decode the incoming item: saturate the byte count, drop unused codes and empty blocks
	always_comb begin
		in_data_item = (in_data.func == ghash_pkg::FUNC_AAD)
			|| (in_data.func == ghash_pkg::FUNC_CIPHER);
		nbytes = (in_data.byte_count > 5'(ghash_pkg::BLOCK_BYTES))
			? 5'(ghash_pkg::BLOCK_BYTES) : in_data.byte_count;
		nbits = {nbytes, 3'b000};
		keep_mask = ~({128{1'b1}} >> nbits);
		in_keep = (in_data.func == ghash_pkg::FUNC_FINISH)
			|| (in_data_item && (nbytes != 5'd0));
	end

	// Advance the staged item unless it is a finish blocked by a waiting tag
	assign s1_go    = valid_s1 && !(fin_s1 && out_valid_q && !out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign in_fire  = in_valid && in_ready;

	// Input stage: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_fire && in_keep;
		end
	end

	// Input stage: function flags, masked block and bit count
	always_ff @(posedge clk) begin
		if (in_fire) begin
			fin_s1   <= (in_data.func == ghash_pkg::FUNC_FINISH);
			aad_s1   <= (in_data.func == ghash_pkg::FUNC_AAD);
			blk_s1   <= {in_data.block_high, in_data.block_low} & keep_mask;
			nbits_s1 <= nbits;
		end
	end

	// One shared multiplier: data block or lengths block
	assign mul_in  = acc_q ^ (fin_s1 ? {data_bits_q, cipher_bits_q} : blk_s1);
	assign mul_out = gf_mul(mul_in, {key_high_q, key_low_q});

	// Fold a staged data item into the accumulator and counters; a staged finish clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			data_bits_q   <= '0;
			cipher_bits_q <= '0;
		end else if (s1_go) begin
			if (fin_s1) begin
				acc_q         <= '0;
				data_bits_q   <= '0;
				cipher_bits_q <= '0;
			end else begin
				acc_q <= mul_out;
				if (aad_s1) begin
					data_bits_q <= data_bits_q + {56'b0, nbits_s1};
				end else begin
					cipher_bits_q <= cipher_bits_q + {56'b0, nbits_s1};
				end
			end
		end
	end

	// Tag register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && fin_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && fin_s1) begin
			out_q <= {mul_out[127:64], mul_out[63:0]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### design/ghash_chk.sv
// Port checker for the GHASH accumulator, bound to the top level.
// Depends on ghash_pkg and on the assertion macros in ghash_accumulator_defines.svh.
`include "ghash_accumulator_defines.svh"

module ghash_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input ghash_pkg::ghash_in_t  in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input ghash_pkg::ghash_out_t out_data
);

	logic fin_fire;

	assign fin_fire = in_valid && in_ready && (in_data.func == ghash_pkg::FUNC_FINISH);

	// No tag is shown in the cycle after an edge seen in reset
	`GHASH_ASSERT_ALWAYS(a_no_tag_in_reset, clk, !arst_n |=> !out_valid, "tag valid after reset")

	// Input stalls only behind a tag that is not taken
	`GHASH_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> (out_valid && !out_ready), "input stalled without a waiting tag")

	// An accepted finish gives a tag on out_valid when the tag register is free for it
	`GHASH_ASSERT_NEXT(a_finish_tag, clk, arst_n, fin_fire ##1 (out_ready || !out_valid), out_valid, "finish item gave no tag")

	// A waiting tag holds its value
	`GHASH_ASSERT_NEXT(a_tag_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "waiting tag changed")

endmodule

bind ghash_accumulator ghash_chk u_ghash_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
